// File: hdl/fpq_pkg.sv
// ----------------------------------------------------------------------------
// fpq_pkg
// Shared types and constants of the float-to-PCM16 dither quantizer.
// ----------------------------------------------------------------------------
package fpq_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int FLOAT_W = 32;
   localparam int EXP_W   = 8;
   localparam int SIG_W   = 24;
   localparam int AMT_W   = 5;
   localparam int DITH_W  = 16;
   localparam int SEED_W  = 31;
   localparam int PCM_W   = 16;
   localparam int SHL_PAD = 20;
   localparam int MAG_W   = SIG_W + SHL_PAD;

   localparam logic [SEED_W-1:0] SEED_RESET = 31'h16BA2118;
   localparam logic [SEED_W-1:0] LCG_MUL    = 31'd1103515245;
   localparam logic [SEED_W-1:0] LCG_ADD    = 31'd12345;

   localparam logic [EXP_W-1:0] EXP_SPECIAL = 8'hFF;
   localparam logic [EXP_W-1:0] EXP_ZERO    = 8'h00;
   localparam logic [EXP_W-1:0] EXP_POINT   = 8'd119;
   localparam logic [EXP_W-1:0] SHR_LIMIT   = 8'd24;
   localparam logic [EXP_W-1:0] SHL_LIMIT   = 8'd20;

   localparam logic [PCM_W-1:0] PCM_MAX = 16'h7FFF;
   localparam logic [PCM_W-1:0] PCM_MIN = 16'h8000;

   typedef enum logic [1:0] {
      CLASS_NORMAL,
      CLASS_ZERO,
      CLASS_SPECIAL
   } class_type;

   typedef struct packed {
      class_type               cls;
      logic                    neg;
      logic                    shl;
      logic [AMT_W-1:0]        amt;
      logic [SIG_W-1:0]        sig;
      logic [DITH_W-1:0]       dither;
      logic                    block_end;
   } entry_type;

endpackage

// File: hdl/float_to_pcm16_dither_quantizer_top.sv
// ----------------------------------------------------------------------------
// float_to_pcm16_dither_quantizer_top
// Converts single-precision audio samples to saturated 16-bit PCM with
// optional linear congruential dither.
// ----------------------------------------------------------------------------
//   Channel   Ports                                   Transfer
//   input     push, full, req_float_bits,             push && !full
//             req_block_end
//   result    empty, pop, rsp_pcm_sample,             pop && !empty
//             rsp_block_end_out
//   config    csr_write_enable, csr_write_data        csr_write_enable
//
// One sample per cycle sustained while the result side keeps popping. An
// accepted sample is written into a queue slot and from there loaded into the
// output register when nothing waits ahead of it; empty falls once it is there.
// The front cycle is set by the generator multiply, the back cycle by the
// exponent shift and the dither add. Synchronous reset empties the queue and
// the output, turns dither off and reloads the generator seed. A four-word
// queue absorbs result stalls; full rises once it holds four words.
// ----------------------------------------------------------------------------
module float_to_pcm16_dither_quantizer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic                             csr_write_data,
   input  logic                             push,
   output logic                             full,
   input  logic [fpq_pkg::FLOAT_W-1:0]      req_float_bits,
   input  logic                             req_block_end,
   output logic                             empty,
   input  logic                             pop,
   output logic signed [fpq_pkg::PCM_W-1:0] rsp_pcm_sample,
   output logic                             rsp_block_end_out
);
   import fpq_pkg::*;

   logic      accept;
   entry_type front_entry;
   logic      head_valid;
   entry_type head_entry;
   logic      take;

   fpq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .float_bits       (req_float_bits),
      .block_end        (req_block_end),
      .queue_full       (full),
      .accept           (accept),
      .entry            (front_entry)
   );

   fpq_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .write       (accept),
      .write_entry (front_entry),
      .take        (take),
      .full        (full),
      .head_valid  (head_valid),
      .head_entry  (head_entry)
   );

   fpq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .take          (take),
      .pop           (pop),
      .empty         (empty),
      .pcm_sample    (rsp_pcm_sample),
      .block_end_out (rsp_block_end_out)
   );

endmodule

// File: hdl/fpq_front.sv
// ----------------------------------------------------------------------------
// fpq_front
// Accepts samples, advances the dither generator if enabled and classifies each float.
// ----------------------------------------------------------------------------
module fpq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   input  logic                          push,
   input  logic [fpq_pkg::FLOAT_W-1:0]   float_bits,
   input  logic                          block_end,
   input  logic                          queue_full,
   output logic                          accept,
   output fpq_pkg::entry_type            entry
);
   import fpq_pkg::*;

   logic              dither_enable_ff;
   logic              dither_enable_in;
   logic [SEED_W-1:0] seed_ff;
   logic [SEED_W-1:0] seed_in;
   logic [SEED_W-1:0] seed_next;
   logic [EXP_W-1:0]  exp_field;
   logic [EXP_W-1:0]  up_amt;
   logic [EXP_W-1:0]  down_amt;

   assign accept    = push && !queue_full;
   assign seed_next = seed_ff * LCG_MUL + LCG_ADD;
   assign exp_field = float_bits[FLOAT_W-2 -: EXP_W];
   assign up_amt    = exp_field - EXP_POINT;
   assign down_amt  = EXP_POINT - exp_field;

   always_comb begin
      dither_enable_in = csr_write_enable ? csr_write_data : dither_enable_ff;
      seed_in          = (accept && dither_enable_ff) ? seed_next : seed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_enable_ff <= 1'b0;
         seed_ff          <= SEED_RESET;
      end else begin
         dither_enable_ff <= dither_enable_in;
         seed_ff          <= seed_in;
      end
   end

   always_comb begin
      entry.neg       = float_bits[FLOAT_W-1];
      entry.sig       = {1'b1, float_bits[SIG_W-2:0]};
      entry.block_end = block_end;
      entry.dither    = dither_enable_ff ? seed_next[SEED_W-1 -: DITH_W] : '0;
      entry.shl       = 1'b1;
      entry.amt       = '0;
      entry.cls       = CLASS_NORMAL;
      priority if (exp_field == EXP_SPECIAL) begin
         entry.cls = CLASS_SPECIAL;
      end else if (exp_field == EXP_ZERO) begin
         entry.cls = CLASS_ZERO;
      end else if (exp_field >= EXP_POINT) begin
         // Larger exponents all saturate, so the left shift is capped.
         entry.amt = (up_amt > SHL_LIMIT) ? SHL_LIMIT[AMT_W-1:0] : up_amt[AMT_W-1:0];
      end else if (down_amt >= SHR_LIMIT) begin
         entry.cls = CLASS_ZERO;
      end else begin
         entry.shl = 1'b0;
         entry.amt = down_amt[AMT_W-1:0];
      end
   end

endmodule

// File: hdl/fpq_queue.sv
// ----------------------------------------------------------------------------
// fpq_queue
// Short queue of classified samples between the front and the back.
// ----------------------------------------------------------------------------
module fpq_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                write,
   input  fpq_pkg::entry_type  write_entry,
   input  logic                take,
   output logic                full,
   output logic                head_valid,
   output fpq_pkg::entry_type  head_entry
);
   import fpq_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_write;
   logic                   do_take;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_write   = write && !full;
   assign do_take    = take && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_take) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_take) begin
         count_in = count_ff + 1'b1;
      end else if (do_take && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         slot_ff[wr_ptr_ff] <= write_entry;
      end
   end

endmodule

// File: hdl/fpq_back.sv
// ----------------------------------------------------------------------------
// fpq_back
// Scales, dithers, truncates and saturates one sample per cycle while the output is free.
// ----------------------------------------------------------------------------
module fpq_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  fpq_pkg::entry_type               head_entry,
   output logic                             take,
   input  logic                             pop,
   output logic                             empty,
   output logic signed [fpq_pkg::PCM_W-1:0] pcm_sample,
   output logic                             block_end_out
);
   import fpq_pkg::*;

   logic             out_valid_ff;
   logic             out_valid_in;
   logic [PCM_W-1:0] pcm_ff;
   logic [PCM_W-1:0] pcm_in;
   logic             block_end_ff;
   logic [MAG_W-1:0] mag;
   logic [MAG_W:0]   sum;
   logic [MAG_W:0]   diff;
   logic             out_free;

   assign out_free      = !out_valid_ff || pop;
   assign take          = head_valid && out_free;
   assign empty         = !out_valid_ff;
   assign pcm_sample    = $signed(pcm_ff);
   assign block_end_out = block_end_ff;

   // Magnitude of the sample times 2^31, truncated.
   assign mag  = head_entry.shl
               ? ({{SHL_PAD{1'b0}}, head_entry.sig} << head_entry.amt)
               : ({{SHL_PAD{1'b0}}, head_entry.sig} >> head_entry.amt);
   assign sum  = {1'b0, mag} + {{(MAG_W + 1 - DITH_W){1'b0}}, head_entry.dither};
   assign diff = {1'b0, mag} - {{(MAG_W + 1 - DITH_W){1'b0}}, head_entry.dither};

   always_comb begin
      pcm_in = '0;
      unique case (head_entry.cls)
         CLASS_SPECIAL: pcm_in = head_entry.neg ? PCM_MIN : PCM_MAX;
         CLASS_ZERO:    pcm_in = '0;
         CLASS_NORMAL: begin
            if (!head_entry.neg) begin
               pcm_in = (|sum[MAG_W:DITH_W+PCM_W-1]) ? PCM_MAX : sum[DITH_W +: PCM_W];
            end else if (diff[MAG_W]) begin
               // Dither larger than the magnitude truncates to zero.
               pcm_in = '0;
            end else if (|diff[MAG_W-1:DITH_W+PCM_W-1]) begin
               pcm_in = PCM_MIN;
            end else begin
               pcm_in = ~diff[DITH_W +: PCM_W] + 1'b1;
            end
         end
         default: pcm_in = '0;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pcm_ff       <= pcm_in;
         block_end_ff <= head_entry.block_end;
      end
   end

endmodule

// File: hdl/fpq_checker.sv
// ----------------------------------------------------------------------------
// fpq_checker
// Port-level checks of the quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module fpq_checker (
   input logic               clock,
   input logic               reset,
   input logic               push,
   input logic               full,
   input logic               empty,
   input logic               pop,
   input logic signed [15:0] rsp_pcm_sample,
   input logic               rsp_block_end_out
);

   // After reset no word is offered and the queue is not full.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queue or output not cleared by reset");

   // A stalled result word holds its value.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_pcm_sample)
                            && $stable(rsp_block_end_out)))
      else $error("stalled result word changed");

   // The back drains the queue whenever the output is free, so a full
   // queue always has a word on the result ports.
   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      full |-> !empty)
      else $error("queue full while output register is empty");

   // A word pushed while the output is empty passes a queue slot and the output register, then shows up.
   a_push_latency: assert property (@(posedge clock) disable iff (reset)
      (push && !full && empty) |=> ##1 !empty)
      else $error("accepted word did not reach the result ports");

endmodule

bind float_to_pcm16_dither_quantizer_top fpq_checker u_fpq_checker (.*);
